FILE: design/cln_pkg.sv
// Package with the types, constants and helper functions of the neighbour search.
`timescale 1ns / 1ps
package cln_pkg;

	localparam int POS_W  = 24;
	localparam int LINK_W = 11;
	localparam int SQ_W   = 48;
	localparam int BOX_W  = 24;
	localparam int RCH_W  = 3;
	localparam int BC_W   = 6;
	localparam int AXN_W  = 4;
	localparam int IMG_W  = 4;
	localparam int CNT_W  = 6;
	localparam int OFF_W  = 29;
	localparam int MAG_W  = 28;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 48;

	localparam logic [1:0] MODE_ATOM  = 2'd0;
	localparam logic [1:0] MODE_HEAD  = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	localparam logic [CFG_AW-1:0] REG_CUTOFF  = 3'd0;
	localparam logic [CFG_AW-1:0] REG_BOX_X   = 3'd1;
	localparam logic [CFG_AW-1:0] REG_BOX_Y   = 3'd2;
	localparam logic [CFG_AW-1:0] REG_BOX_Z   = 3'd3;
	localparam logic [CFG_AW-1:0] REG_REACH_X = 3'd4;
	localparam logic [CFG_AW-1:0] REG_REACH_Y = 3'd5;
	localparam logic [CFG_AW-1:0] REG_REACH_Z = 3'd6;

	localparam logic KIND_ENTRY   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic signed [LINK_W-1:0] LINK_END = -11'sd1;

	typedef struct packed {
		logic                    valid;
		logic [POS_W-1:0]        px;
		logic [POS_W-1:0]        py;
		logic [POS_W-1:0]        pz;
		logic [POS_W-1:0]        sx;
		logic [POS_W-1:0]        sy;
		logic [POS_W-1:0]        sz;
		logic signed [OFF_W-1:0] offx;
		logic signed [OFF_W-1:0] offy;
		logic signed [OFF_W-1:0] offz;
	} dist_req_t;

	function automatic logic [BC_W-1:0] wrap_coord(input logic [2:0] c, input int nb);
		logic [6:0] v;
		v = {4'b0, c};
		for (int i = 0; i < 8; i++) begin
			if (int'(v) >= nb) v = v - 7'(nb);
		end
		return v[BC_W-1:0];
	endfunction

	function automatic logic [BC_W-1:0] axis_start(input logic [BC_W-1:0] cw,
		input logic [RCH_W-1:0] r, input int nb);
		logic signed [7:0] v;
		v = $signed({2'b0, cw}) - $signed({5'b0, r});
		for (int i = 0; i < 8; i++) begin
			if (v < 0) v = v + 8'(nb);
		end
		return v[BC_W-1:0];
	endfunction

	function automatic logic [AXN_W-1:0] axis_count(input logic [RCH_W-1:0] r, input int nb);
		logic [6:0] n;
		n = {3'b0, r, 1'b1};
		if (int'(n) > nb) n = 7'(nb);
		return n[AXN_W-1:0];
	endfunction

endpackage

FILE: design/cln_if.sv
// Channel interfaces for queries, results and configuration writes.
`timescale 1ns / 1ps
interface cln_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 mode;
	logic [9:0]                 atom_index;
	logic [23:0]                pos_x;
	logic [23:0]                pos_y;
	logic [23:0]                pos_z;
	logic signed [10:0]         next_atom;
	logic [2:0]                 bin_x;
	logic [2:0]                 bin_y;
	logic [2:0]                 bin_z;
	logic signed [10:0]         head_atom;
	modport source (output valid, mode, atom_index, pos_x, pos_y, pos_z, next_atom,
		bin_x, bin_y, bin_z, head_atom, input ready);
	modport sink (input valid, mode, atom_index, pos_x, pos_y, pos_z, next_atom,
		bin_x, bin_y, bin_z, head_atom, output ready);
endinterface

interface cln_rsp_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [9:0]         neighbor_atom;
	logic signed [3:0]  image_x;
	logic signed [3:0]  image_y;
	logic signed [3:0]  image_z;
	logic [5:0]         neighbor_count;
	logic               overflow;
	logic               last;
	modport source (output valid, kind, neighbor_atom, image_x, image_y, image_z,
		neighbor_count, overflow, last, input ready);
	modport sink (input valid, kind, neighbor_atom, image_x, image_y, image_z,
		neighbor_count, overflow, last, output ready);
endinterface

interface cln_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  addr;
	logic [47:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

FILE: design/cln_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module cln_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: design/cln_dist.sv
// Squared periodic distance unit: difference stage, square stage, saturating compare.
`timescale 1ns / 1ps
module cln_dist (
	input  logic                           clk,
	input  cln_pkg::dist_req_t             req,
	input  logic [cln_pkg::SQ_W-1:0]       cutoff_sq,
	output logic                           hit
);
	logic signed [cln_pkg::OFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic [2*cln_pkg::MAG_W-1:0]      sqx_s2, sqy_s2, sqz_s2;
	logic [cln_pkg::MAG_W-1:0]        mx, my, mz;
	logic [2*cln_pkg::MAG_W+1:0]      sum;
	logic [cln_pkg::SQ_W-1:0]         sat;

	always_ff @(posedge clk) begin
		if (req.valid) begin
			dx_s1 <= $signed({5'b0, req.px}) - req.offx - $signed({5'b0, req.sx});
			dy_s1 <= $signed({5'b0, req.py}) - req.offy - $signed({5'b0, req.sy});
			dz_s1 <= $signed({5'b0, req.pz}) - req.offz - $signed({5'b0, req.sz});
		end
	end

	always_comb begin
		mx = dx_s1[cln_pkg::OFF_W-1] ? cln_pkg::MAG_W'(-dx_s1) : cln_pkg::MAG_W'(dx_s1);
		my = dy_s1[cln_pkg::OFF_W-1] ? cln_pkg::MAG_W'(-dy_s1) : cln_pkg::MAG_W'(dy_s1);
		mz = dz_s1[cln_pkg::OFF_W-1] ? cln_pkg::MAG_W'(-dz_s1) : cln_pkg::MAG_W'(dz_s1);
	end

	always_ff @(posedge clk) begin
		sqx_s2 <= mx * mx;
		sqy_s2 <= my * my;
		sqz_s2 <= mz * mz;
	end

	always_comb begin
		sum = {2'b0, sqx_s2} + {2'b0, sqy_s2} + {2'b0, sqz_s2};
		sat = (|sum[2*cln_pkg::MAG_W+1:cln_pkg::SQ_W]) ? '1 : sum[cln_pkg::SQ_W-1:0];
		hit = sat < cutoff_sq;
	end
endmodule

FILE: design/cell_list_neighbor_search.sv
// Top level of the cell-list neighbour search with periodic images.
//
//   channel | dir | handshake   | carries
//   req     | in  | valid/ready | mode, atom, position, link, bin, head
//   rsp     | out | valid/ready | neighbour entries, then one summary
//   cfg     | in  | valid/ready | register index and write data
//
// After reset a clearing pass writes every bin head empty, one bin a cycle;
// no request is taken until it ends. Atom and head writes happen on accept.
// Per bin a query runs ST_BIN, ST_HEAD, ST_LINK; per atom ST_LINK, ST_ATOM;
// per shift tested ST_IMG, ST_SQ, ST_CMP, as the shared distance unit tests
// one shift at a time. A full result register holds the scan until taken.
`timescale 1ns / 1ps
module cell_list_neighbor_search #(
	parameter int MAX_ATOMS     = 1024,
	parameter int BINS_X        = 8,
	parameter int BINS_Y        = 8,
	parameter int BINS_Z        = 8,
	parameter int MAX_NEIGHBORS = 63
) (
	input  logic      clk,
	input  logic      arst_n,
	cln_req_if.sink   req,
	cln_rsp_if.source rsp,
	cln_cfg_if.sink   cfg
);
	localparam int NBINS = BINS_X * BINS_Y * BINS_Z;
	localparam int AAW   = MAX_ATOMS > 1 ? $clog2(MAX_ATOMS) : 1;
	localparam int HAW   = NBINS > 1 ? $clog2(NBINS) : 1;
	localparam int WK_W  = $clog2(MAX_ATOMS + 1);
	localparam int AW_W  = 3 * cln_pkg::POS_W + cln_pkg::LINK_W;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_OWN, ST_BIN, ST_HEAD, ST_LINK,
		ST_ATOM, ST_IMG, ST_SQ, ST_CMP, ST_SUM
	} state_t;

	state_t state_q;

	logic [cln_pkg::SQ_W-1:0]  cutoff_q;
	logic [cln_pkg::BOX_W-1:0] box_x_q, box_y_q, box_z_q;
	logic [cln_pkg::RCH_W-1:0] rx_q, ry_q, rz_q;

	logic [HAW-1:0]                     clr_q;
	logic [9:0]                         ai_q;
	logic [cln_pkg::POS_W-1:0]          px_q, py_q, pz_q, sx_q, sy_q, sz_q;
	logic signed [cln_pkg::LINK_W-1:0]  s_q, link_q;
	logic [WK_W-1:0]                    walked_q;
	logic [cln_pkg::CNT_W-1:0]          count_q;
	logic                               ovf_q;
	logic [cln_pkg::AXN_W-1:0]          ia_q, ib_q, ic_q, nx_q, ny_q, nz_q;
	logic [cln_pkg::BC_W-1:0]           cx_q, cy_q, cz_q, bx0_q, by0_q, bz0_q;
	logic signed [cln_pkg::IMG_W-1:0]   e_q, f_q, g_q;
	logic signed [cln_pkg::OFF_W-1:0]   offx_q, offy_q, offz_q;

	logic                               out_valid_q;
	logic                               out_kind_q, out_ovf_q, out_last_q;
	logic [9:0]                         out_atom_q;
	logic signed [cln_pkg::IMG_W-1:0]   out_ix_q, out_iy_q, out_iz_q;
	logic [cln_pkg::CNT_W-1:0]          out_cnt_q;

	logic                     atom_we, head_we;
	logic [AAW-1:0]           atom_waddr, atom_raddr;
	logic [AW_W-1:0]          atom_wdata, atom_rdata;
	logic [HAW-1:0]           head_waddr, head_raddr;
	logic [cln_pkg::LINK_W-1:0] head_wdata, head_rdata;

	cln_pkg::dist_req_t       dreq;
	logic                     hit, out_free, self_img, adv, req_fire;
	logic                     ai_ok, full;
	logic [cln_pkg::BC_W-1:0] hbx, hby, hbz, qbx, qby, qbz;
	logic signed [cln_pkg::OFF_W-1:0] stx, sty, stz;
	logic signed [cln_pkg::IMG_W-1:0] rxs, rys, rzs;

	function automatic logic [HAW-1:0] head_addr(input logic [cln_pkg::BC_W-1:0] x,
		input logic [cln_pkg::BC_W-1:0] y, input logic [cln_pkg::BC_W-1:0] z);
		int a;
		a = (int'(x) * BINS_Y + int'(y)) * BINS_Z + int'(z);
		return HAW'(a);
	endfunction

	function automatic logic link_ok(input logic signed [cln_pkg::LINK_W-1:0] v);
		return !v[cln_pkg::LINK_W-1] && (int'(v[9:0]) < MAX_ATOMS);
	endfunction

	function automatic logic [cln_pkg::BC_W-1:0] bin_inc(input logic [cln_pkg::BC_W-1:0] c,
		input int nb);
		return (int'(c) + 1 == nb) ? '0 : c + 1'b1;
	endfunction

	function automatic logic signed [cln_pkg::OFF_W-1:0] off_start(
		input logic [cln_pkg::RCH_W-1:0] r, input logic [cln_pkg::BOX_W-1:0] b);
		logic [26:0] m;
		m = r * b;
		return cln_pkg::OFF_W'(0) - {2'b0, m};
	endfunction

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= '0;
			box_x_q  <= '0;
			box_y_q  <= '0;
			box_z_q  <= '0;
			rx_q     <= 3'd1;
			ry_q     <= 3'd1;
			rz_q     <= 3'd1;
		end else if (cfg.valid) begin
			case (cfg.addr)
				cln_pkg::REG_CUTOFF:  cutoff_q <= cfg.data;
				cln_pkg::REG_BOX_X:   box_x_q  <= cfg.data[cln_pkg::BOX_W-1:0];
				cln_pkg::REG_BOX_Y:   box_y_q  <= cfg.data[cln_pkg::BOX_W-1:0];
				cln_pkg::REG_BOX_Z:   box_z_q  <= cfg.data[cln_pkg::BOX_W-1:0];
				cln_pkg::REG_REACH_X: rx_q     <= cfg.data[cln_pkg::RCH_W-1:0];
				cln_pkg::REG_REACH_Y: ry_q     <= cfg.data[cln_pkg::RCH_W-1:0];
				cln_pkg::REG_REACH_Z: rz_q     <= cfg.data[cln_pkg::RCH_W-1:0];
				default: ;
			endcase
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign ai_ok     = int'(req.atom_index) < MAX_ATOMS;

	assign hbx = cln_pkg::wrap_coord(req.bin_x, BINS_X);
	assign hby = cln_pkg::wrap_coord(req.bin_y, BINS_Y);
	assign hbz = cln_pkg::wrap_coord(req.bin_z, BINS_Z);
	assign qbx = cln_pkg::axis_start(hbx, rx_q, BINS_X);
	assign qby = cln_pkg::axis_start(hby, ry_q, BINS_Y);
	assign qbz = cln_pkg::axis_start(hbz, rz_q, BINS_Z);

	assign atom_we    = req_fire && req.mode == cln_pkg::MODE_ATOM && ai_ok;
	assign atom_waddr = AAW'(req.atom_index);
	assign atom_wdata = {req.next_atom, req.pos_z, req.pos_y, req.pos_x};
	assign atom_raddr = (state_q == ST_IDLE) ? AAW'(req.atom_index) : AAW'(s_q[9:0]);

	assign head_we    = (state_q == ST_CLEAR) ||
		(req_fire && req.mode == cln_pkg::MODE_HEAD);
	assign head_waddr = (state_q == ST_CLEAR) ? clr_q : head_addr(hbx, hby, hbz);
	assign head_wdata = (state_q == ST_CLEAR) ? cln_pkg::LINK_END : req.head_atom;
	assign head_raddr = head_addr(cx_q, cy_q, cz_q);

	cln_ram #(.WIDTH(AW_W), .DEPTH(MAX_ATOMS)) u_atom_ram (
		.clk(clk), .we(atom_we), .waddr(atom_waddr), .wdata(atom_wdata),
		.raddr(atom_raddr), .rdata(atom_rdata)
	);

	cln_ram #(.WIDTH(cln_pkg::LINK_W), .DEPTH(NBINS)) u_head_ram (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rdata)
	);

	assign stx = off_start(rx_q, box_x_q);
	assign sty = off_start(ry_q, box_y_q);
	assign stz = off_start(rz_q, box_z_q);
	assign rxs = $signed({1'b0, rx_q});
	assign rys = $signed({1'b0, ry_q});
	assign rzs = $signed({1'b0, rz_q});

	assign self_img = (s_q[9:0] == ai_q) && e_q == 0 && f_q == 0 && g_q == 0;
	assign full     = (count_q == cln_pkg::CNT_W'(MAX_NEIGHBORS));
	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		dreq       = '0;
		dreq.valid = (state_q == ST_IMG) && !self_img;
		dreq.px    = px_q;
		dreq.py    = py_q;
		dreq.pz    = pz_q;
		dreq.sx    = sx_q;
		dreq.sy    = sy_q;
		dreq.sz    = sz_q;
		dreq.offx  = offx_q;
		dreq.offy  = offy_q;
		dreq.offz  = offz_q;
	end

	cln_dist u_dist (.clk(clk), .req(dreq), .cutoff_sq(cutoff_q), .hit(hit));

	assign adv = (state_q == ST_IMG && self_img) ||
		(state_q == ST_CMP && (!hit || (!full && out_free)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			ai_q        <= '0;
			px_q        <= '0; py_q <= '0; pz_q <= '0;
			sx_q        <= '0; sy_q <= '0; sz_q <= '0;
			s_q         <= '0;
			link_q      <= '0;
			walked_q    <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			ia_q        <= '0; ib_q <= '0; ic_q <= '0;
			nx_q        <= '0; ny_q <= '0; nz_q <= '0;
			cx_q        <= '0; cy_q <= '0; cz_q <= '0;
			bx0_q       <= '0; by0_q <= '0; bz0_q <= '0;
			e_q         <= '0; f_q <= '0; g_q <= '0;
			offx_q      <= '0; offy_q <= '0; offz_q <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
			out_last_q  <= 1'b0;
			out_atom_q  <= '0;
			out_ix_q    <= '0; out_iy_q <= '0; out_iz_q <= '0;
			out_cnt_q   <= '0;
		end else begin
			if (out_valid_q && rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == HAW'(NBINS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req_fire && req.mode == cln_pkg::MODE_QUERY) begin
						ai_q     <= req.atom_index;
						count_q  <= '0;
						ovf_q    <= 1'b0;
						walked_q <= '0;
						ia_q     <= '0; ib_q <= '0; ic_q <= '0;
						nx_q     <= cln_pkg::axis_count(rx_q, BINS_X);
						ny_q     <= cln_pkg::axis_count(ry_q, BINS_Y);
						nz_q     <= cln_pkg::axis_count(rz_q, BINS_Z);
						cx_q     <= qbx; cy_q <= qby; cz_q <= qbz;
						bx0_q    <= qbx; by0_q <= qby; bz0_q <= qbz;
						state_q  <= ai_ok ? ST_OWN : ST_SUM;
					end
				end
				ST_OWN: begin
					px_q    <= atom_rdata[cln_pkg::POS_W-1:0];
					py_q    <= atom_rdata[2*cln_pkg::POS_W-1:cln_pkg::POS_W];
					pz_q    <= atom_rdata[3*cln_pkg::POS_W-1:2*cln_pkg::POS_W];
					state_q <= ST_BIN;
				end
				ST_BIN: state_q <= ST_HEAD;
				ST_HEAD: begin
					s_q     <= head_rdata;
					state_q <= ST_LINK;
				end
				ST_LINK: begin
					if (link_ok(s_q)) begin
						if (int'(walked_q) >= MAX_ATOMS) begin
							state_q <= ST_SUM;
						end else begin
							walked_q <= walked_q + 1'b1;
							state_q  <= ST_ATOM;
						end
					end else if (ic_q + 1'b1 < nz_q) begin
						ic_q    <= ic_q + 1'b1;
						cz_q    <= bin_inc(cz_q, BINS_Z);
						state_q <= ST_BIN;
					end else if (ib_q + 1'b1 < ny_q) begin
						ib_q    <= ib_q + 1'b1;
						cy_q    <= bin_inc(cy_q, BINS_Y);
						ic_q    <= '0;
						cz_q    <= bz0_q;
						state_q <= ST_BIN;
					end else if (ia_q + 1'b1 < nx_q) begin
						ia_q    <= ia_q + 1'b1;
						cx_q    <= bin_inc(cx_q, BINS_X);
						ib_q    <= '0;
						cy_q    <= by0_q;
						ic_q    <= '0;
						cz_q    <= bz0_q;
						state_q <= ST_BIN;
					end else begin
						state_q <= ST_SUM;
					end
				end
				ST_ATOM: begin
					sx_q    <= atom_rdata[cln_pkg::POS_W-1:0];
					sy_q    <= atom_rdata[2*cln_pkg::POS_W-1:cln_pkg::POS_W];
					sz_q    <= atom_rdata[3*cln_pkg::POS_W-1:2*cln_pkg::POS_W];
					link_q  <= atom_rdata[AW_W-1:3*cln_pkg::POS_W];
					e_q     <= -rxs; f_q <= -rys; g_q <= -rzs;
					offx_q  <= stx; offy_q <= sty; offz_q <= stz;
					state_q <= ST_IMG;
				end
				ST_IMG: if (!self_img) state_q <= ST_SQ;
				ST_SQ:  state_q <= ST_CMP;
				ST_CMP: begin
					if (hit && full) begin
						ovf_q   <= 1'b1;
						state_q <= ST_SUM;
					end else if (hit && out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= cln_pkg::KIND_ENTRY;
						out_atom_q  <= s_q[9:0];
						out_ix_q    <= e_q;
						out_iy_q    <= f_q;
						out_iz_q    <= g_q;
						out_cnt_q   <= '0;
						out_ovf_q   <= 1'b0;
						out_last_q  <= 1'b0;
						count_q     <= count_q + 1'b1;
					end
				end
				ST_SUM: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= cln_pkg::KIND_SUMMARY;
						out_atom_q  <= '0;
						out_ix_q    <= '0;
						out_iy_q    <= '0;
						out_iz_q    <= '0;
						out_cnt_q   <= count_q;
						out_ovf_q   <= ovf_q;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (adv) begin
				if (g_q != rzs) begin
					g_q     <= g_q + 1'b1;
					offz_q  <= offz_q + $signed({5'b0, box_z_q});
					state_q <= ST_IMG;
				end else if (f_q != rys) begin
					f_q     <= f_q + 1'b1;
					g_q     <= -rzs;
					offz_q  <= stz;
					offy_q  <= offy_q + $signed({5'b0, box_y_q});
					state_q <= ST_IMG;
				end else if (e_q != rxs) begin
					e_q     <= e_q + 1'b1;
					f_q     <= -rys;
					g_q     <= -rzs;
					offz_q  <= stz;
					offy_q  <= sty;
					offx_q  <= offx_q + $signed({5'b0, box_x_q});
					state_q <= ST_IMG;
				end else begin
					s_q     <= link_q;
					state_q <= ST_LINK;
				end
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.kind           = out_kind_q;
	assign rsp.neighbor_atom  = out_atom_q;
	assign rsp.image_x        = out_ix_q;
	assign rsp.image_y        = out_iy_q;
	assign rsp.image_z        = out_iz_q;
	assign rsp.neighbor_count = out_cnt_q;
	assign rsp.overflow       = out_ovf_q;
	assign rsp.last           = out_last_q;
endmodule
